// ===== design/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants for the bilinear texture sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

    localparam int unsigned TEXEL_W = 24;
    localparam int unsigned COORD_W = 17;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned OUT_W   = 24;
    localparam int unsigned SIZE_W  = 9;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned CFG_W   = 9;

    // largest usable texture; larger size registers are clamped to these
    localparam int unsigned MAX_WIDTH  = 256;
    localparam int unsigned MAX_HEIGHT = 256;

    typedef enum logic [0:0] {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic [0:0] {
        REG_TEX_WIDTH  = 1'b0,
        REG_TEX_HEIGHT = 1'b1
    } reg_idx_t;

endpackage

`default_nettype wire

// ===== design/bts_ram.sv =====
// ----------------------------------------------------------------------------
// bts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/bts_sample.sv =====
// ----------------------------------------------------------------------------
// bts_sample
// Address and weight front end: clamps u,v, scales by size-1, splits cell
// and fraction, forms four neighbor addresses with in-range flags and four
// 1.32 weights. Three register stages, advanced by one enable.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_sample
    import bts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire logic [SIZE_W-1:0]  tex_width,
    input  wire logic [SIZE_W-1:0]  tex_height,
    input  wire logic [COORD_W-1:0] coord_u,
    input  wire logic [COORD_W-1:0] coord_v,
    output logic                    out_valid,
    output logic                    out_empty,
    output logic [3:0]              out_inb,
    output logic [ADDR_W-1:0]       out_addr [4],
    output logic [32:0]             out_wt [4]
);

    localparam logic [COORD_W-1:0] ONE = COORD_W'(1 << FRAC_W);

    // stage 1: clamp and scale
    logic [SIZE_W-1:0]  w_eff, h_eff;
    logic [COORD_W-1:0] u_c, v_c;
    logic               s1_valid_reg;
    logic               s1_empty_reg;
    logic [SIZE_W-1:0]  s1_w_reg, s1_h_reg;
    logic [25:0]        s1_px_reg, s1_py_reg;

    assign w_eff = (tex_width  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : tex_width;
    assign h_eff = (tex_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : tex_height;
    assign u_c   = (coord_u > ONE) ? ONE : coord_u;
    assign v_c   = (coord_v > ONE) ? ONE : coord_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_empty_reg <= (w_eff == '0) || (h_eff == '0);
            s1_w_reg     <= w_eff;
            s1_h_reg     <= h_eff;
            s1_px_reg    <= 26'(u_c * (w_eff - SIZE_W'(1)));
            s1_py_reg    <= 26'(v_c * (h_eff - SIZE_W'(1)));
        end
    end

    // stage 2: neighbors, address multiply, weight factors
    logic [9:0]  cx, cy, cx1, cy1;
    logic [16:0] fx, fy, gx, gy;
    logic        s2_valid_reg, s2_empty_reg;
    logic [3:0]  s2_inb_reg;
    logic [17:0] s2_base0_reg, s2_base1_reg;
    logic [9:0]  s2_cx_reg;
    logic [16:0] s2_fx_reg, s2_fy_reg, s2_gx_reg, s2_gy_reg;
    logic        xin0, xin1, yin0, yin1;

    assign cx  = s1_px_reg[25:FRAC_W];
    assign cy  = s1_py_reg[25:FRAC_W];
    assign cx1 = cx + 10'd1;
    assign cy1 = cy + 10'd1;
    assign fx  = {1'b0, s1_px_reg[FRAC_W-1:0]};
    assign fy  = {1'b0, s1_py_reg[FRAC_W-1:0]};
    assign gx  = ONE - fx;
    assign gy  = ONE - fy;
    assign xin0 = cx  < {1'b0, s1_w_reg};
    assign xin1 = cx1 < {1'b0, s1_w_reg};
    assign yin0 = cy  < {1'b0, s1_h_reg};
    assign yin1 = cy1 < {1'b0, s1_h_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_empty_reg <= s1_empty_reg;
            s2_inb_reg   <= {xin1 & yin1, xin0 & yin1, xin1 & yin0, xin0 & yin0};
            s2_base0_reg <= 18'(cy  * s1_w_reg);
            s2_base1_reg <= 18'(cy1 * s1_w_reg);
            s2_cx_reg    <= cx;
            s2_fx_reg    <= fx;
            s2_fy_reg    <= fy;
            s2_gx_reg    <= gx;
            s2_gy_reg    <= gy;
        end
    end

    // stage 3: addresses and weights
    logic [18:0] a [4];
    logic        s3_valid_reg;

    assign a[0] = 19'(s2_base0_reg) + 19'(s2_cx_reg);
    assign a[1] = 19'(s2_base0_reg) + 19'(s2_cx_reg) + 19'd1;
    assign a[2] = 19'(s2_base1_reg) + 19'(s2_cx_reg);
    assign a[3] = 19'(s2_base1_reg) + 19'(s2_cx_reg) + 19'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_empty <= s2_empty_reg;
            for (int k = 0; k < 4; k++)
            begin
                out_inb[k]  <= s2_inb_reg[k] && (a[k][18:ADDR_W] == '0);
                out_addr[k] <= a[k][ADDR_W-1:0];
            end
            out_wt[0] <= 33'(s2_gx_reg * s2_gy_reg);
            out_wt[1] <= 33'(s2_fx_reg * s2_gy_reg);
            out_wt[2] <= 33'(s2_gx_reg * s2_fy_reg);
            out_wt[3] <= 33'(s2_fx_reg * s2_fy_reg);
        end
    end

    assign out_valid = s3_valid_reg;

endmodule

`default_nettype wire

// ===== design/bts_blend.sv =====
// ----------------------------------------------------------------------------
// bts_blend
// Per-channel weighted sum: four products, then a sum, round and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_blend
    import bts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [3:0]        in_use,
    input  wire logic [TEXEL_W-1:0] in_texel [4],
    input  wire logic [32:0]       in_wt [4],
    output logic                   out_valid,
    output logic [OUT_W-1:0]       out_chan [3]
);

    logic        p_valid_reg;
    logic [40:0] p_reg [3][4];
    logic [42:0] acc [3];
    logic        o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= in_valid;
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    p_reg[c][k] <= in_use[k]
                        ? 41'(in_texel[k][(2-c)*CHAN_W +: CHAN_W] * in_wt[k]) : '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = 43'(p_reg[c][0]) + 43'(p_reg[c][1]) + 43'(p_reg[c][2])
                   + 43'(p_reg[c][3]) + 43'h8000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                out_chan[c] <= acc[c][FRAC_W +: OUT_W];
            end
        end
    end

    assign out_valid = o_valid_reg;

endmodule

`default_nettype wire

// ===== design/bilinear_texture_sampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// Texel store with a pipelined bilinear filter behind it.
//
//   channel  direction  handshake           payload
//   in       sink       valid / stall       command, texel_*, coord_*
//   out      source     out_valid/out_stall sample_red/green/blue
//   cfg      sink       cfg_we              cfg_index, cfg_data
//
// One word per cycle while not stalled. A sample passes three
// address stages, one RAM read, a product stage, then the output register.
// Four RAM copies give the four neighbor reads in the same cycle. Texel writes
// trail through three stages so they reach the store in word order.
// The pipeline advances as one unit; stall holds every stage.
// Reset clears valid bits and the size registers; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_texture_sampler
    import bts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid,
    output logic                    stall,
    input  wire logic               command,
    input  wire logic [ADDR_W-1:0]  texel_index,
    input  wire logic [CHAN_W-1:0]  texel_red,
    input  wire logic [CHAN_W-1:0]  texel_green,
    input  wire logic [CHAN_W-1:0]  texel_blue,
    input  wire logic [COORD_W-1:0] coord_u,
    input  wire logic [COORD_W-1:0] coord_v,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [OUT_W-1:0]        sample_red,
    output logic [OUT_W-1:0]        sample_green,
    output logic [OUT_W-1:0]        sample_blue,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    logic [SIZE_W-1:0] tex_width_reg, tex_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= '0;
            tex_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_data;
                REG_TEX_HEIGHT: tex_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic adv, acc_in, is_sample, wr_en;
    assign adv       = !(out_valid && out_stall);
    assign stall     = !adv;
    assign acc_in    = valid && adv;
    assign is_sample = (cmd_t'(command) == CMD_SAMPLE);
    assign wr_en     = acc_in && !is_sample;

    // write delay, matched to the address stages
    logic [2:0]         wq_we_reg;
    logic [ADDR_W-1:0]  wq_addr_reg [3];
    logic [TEXEL_W-1:0] wq_data_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wq_we_reg <= '0;
        end
        else if (adv)
        begin
            wq_we_reg <= {wq_we_reg[1:0], wr_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wq_addr_reg[0] <= texel_index;
            wq_data_reg[0] <= {texel_red, texel_green, texel_blue};
            wq_addr_reg[1] <= wq_addr_reg[0];
            wq_data_reg[1] <= wq_data_reg[0];
            wq_addr_reg[2] <= wq_addr_reg[1];
            wq_data_reg[2] <= wq_data_reg[1];
        end
    end

    logic              a_valid, a_empty;
    logic [3:0]        a_inb;
    logic [ADDR_W-1:0] a_addr [4];
    logic [32:0]       a_wt [4];

    bts_sample u_sample (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (valid && is_sample),
        .tex_width  (tex_width_reg),
        .tex_height (tex_height_reg),
        .coord_u    (coord_u),
        .coord_v    (coord_v),
        .out_valid  (a_valid),
        .out_empty  (a_empty),
        .out_inb    (a_inb),
        .out_addr   (a_addr),
        .out_wt     (a_wt)
    );

    // RAM read stage
    logic [TEXEL_W-1:0] r_texel [4];
    logic               r_valid_reg;
    logic [3:0]         r_use_reg;
    logic [32:0]        r_wt_reg [4];

    for (genvar k = 0; k < 4; k++)
    begin : g_ram
        bts_ram #(
            .WIDTH (TEXEL_W),
            .DEPTH (1 << ADDR_W)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wq_we_reg[2] && adv),
            .wr_addr (wq_addr_reg[2]),
            .wr_data (wq_data_reg[2]),
            .rd_en   (adv),
            .rd_addr (a_addr[k]),
            .rd_data (r_texel[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_use_reg <= a_empty ? 4'b0000 : a_inb;
            r_wt_reg  <= a_wt;
        end
    end

    logic [OUT_W-1:0] b_chan [3];

    bts_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (r_valid_reg),
        .in_use    (r_use_reg),
        .in_texel  (r_texel),
        .in_wt     (r_wt_reg),
        .out_valid (out_valid),
        .out_chan  (b_chan)
    );

    assign sample_red   = b_chan[0];
    assign sample_green = b_chan[1];
    assign sample_blue  = b_chan[2];

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bilinear_texture_sampler. Loads texels, programs
// texture sizes from empty to oversized, and samples at edge and random
// coordinates. An in-bench filter model predicts each sample word. Every
// sample word out of the block is checked against the oldest prediction.
// Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import bts_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_ITEMS    = 70;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } rgb_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               valid = 1'b0;
    logic               stall;
    logic               command = 1'b0;
    logic [ADDR_W-1:0]  texel_index = '0;
    logic [CHAN_W-1:0]  texel_red = '0;
    logic [CHAN_W-1:0]  texel_green = '0;
    logic [CHAN_W-1:0]  texel_blue = '0;
    logic [COORD_W-1:0] coord_u = '0;
    logic [COORD_W-1:0] coord_v = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [OUT_W-1:0]   sample_red;
    logic [OUT_W-1:0]   sample_green;
    logic [OUT_W-1:0]   sample_blue;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [CFG_W-1:0]   cfg_data = '0;

    bilinear_texture_sampler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (valid),
        .stall       (stall),
        .command     (command),
        .texel_index (texel_index),
        .texel_red   (texel_red),
        .texel_green (texel_green),
        .texel_blue  (texel_blue),
        .coord_u     (coord_u),
        .coord_v     (coord_v),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_red  (sample_red),
        .sample_green(sample_green),
        .sample_blue (sample_blue),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    // texture mirror
    logic [TEXEL_W-1:0] texel_mem [65536];
    bit                 texel_written [65536];
    logic [SIZE_W-1:0]  tex_w = '0;
    logic [SIZE_W-1:0]  tex_h = '0;

    rgb_t pending_samples [$];
    int   errors = 0;
    int   burst_left = 0;
    int   idle_cycles = 0;

    task automatic report(input string what, input logic [OUT_W-1:0] got,
                          input logic [OUT_W-1:0] want);
        $display("ERROR t=%0t %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic void locate_cell(input logic [COORD_W-1:0] u_in,
                                        input logic [COORD_W-1:0] v_in,
                                        output longint unsigned w,
                                        output longint unsigned h,
                                        output longint unsigned cx,
                                        output longint unsigned cy,
                                        output longint unsigned fx,
                                        output longint unsigned fy);
        longint unsigned u, v, px, py;
        w = (tex_w > 256) ? 256 : tex_w;
        h = (tex_h > 256) ? 256 : tex_h;
        u = (u_in > 65536) ? 65536 : u_in;
        v = (v_in > 65536) ? 65536 : v_in;
        px = (w == 0) ? 0 : u * (w - 1);
        py = (h == 0) ? 0 : v * (h - 1);
        cx = px >> 16;
        cy = py >> 16;
        fx = px & 16'hFFFF;
        fy = py & 16'hFFFF;
    endfunction

    function automatic logic [TEXEL_W-1:0] texel_at(input longint unsigned x,
                                                    input longint unsigned y,
                                                    input longint unsigned w,
                                                    input longint unsigned h);
        longint unsigned a;
        if (x >= w || y >= h)
            return '0;
        a = x + y * w;
        if (a >= 65536)
            return '0;
        return texel_mem[a];
    endfunction

    function automatic rgb_t filter_sample(input logic [COORD_W-1:0] u_in,
                                           input logic [COORD_W-1:0] v_in);
        longint unsigned w, h, cx, cy, fx, fy, acc;
        longint unsigned wt [4];
        logic [TEXEL_W-1:0] tx [4];
        logic [OUT_W-1:0] chan [3];
        rgb_t res;
        locate_cell(u_in, v_in, w, h, cx, cy, fx, fy);
        if (w == 0 || h == 0)
            return '0;
        wt[0] = (65536 - fx) * (65536 - fy);
        wt[1] = fx * (65536 - fy);
        wt[2] = (65536 - fx) * fy;
        wt[3] = fx * fy;
        tx[0] = texel_at(cx, cy, w, h);
        tx[1] = texel_at(cx + 1, cy, w, h);
        tx[2] = texel_at(cx, cy + 1, w, h);
        tx[3] = texel_at(cx + 1, cy + 1, w, h);
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += longint'((tx[k] >> (16 - 8 * ch)) & 8'hFF) * wt[k];
            chan[ch] = OUT_W'((acc + 32'h8000) >> 16);
        end
        res.red = chan[0];
        res.green = chan[1];
        res.blue = chan[2];
        return res;
    endfunction

    // drive one word; called at a rising edge, returns at the accepting edge
    task automatic send_word(input cmd_t cmd, input logic [ADDR_W-1:0] idx,
                             input logic [TEXEL_W-1:0] rgb,
                             input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
        if (burst_left == 0)
        begin
            valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        valid       <= 1'b1;
        command     <= cmd;
        texel_index <= idx;
        texel_red   <= rgb[23:16];
        texel_green <= rgb[15:8];
        texel_blue  <= rgb[7:0];
        coord_u     <= u;
        coord_v     <= v;
        do @(posedge clk); while (stall);
        if (cmd == CMD_WRITE)
        begin
            texel_mem[idx] = rgb;
            texel_written[idx] = 1'b1;
        end
        else
            pending_samples.push_back(filter_sample(u, v));
    endtask

    task automatic write_texel(input logic [ADDR_W-1:0] idx, input logic [TEXEL_W-1:0] rgb);
        send_word(CMD_WRITE, idx, rgb, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // load any neighbor the sample would read that holds no data yet
    task automatic sample_at(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
        longint unsigned w, h, cx, cy, fx, fy, x, y, a;
        locate_cell(u, v, w, h, cx, cy, fx, fy);
        for (int k = 0; k < 4; k++)
        begin
            x = cx + (k & 1);
            y = cy + (k >> 1);
            a = x + y * w;
            if (x < w && y < h && a < 65536 && !texel_written[a])
                write_texel(ADDR_W'(a), TEXEL_W'($urandom));
        end
        send_word(CMD_SAMPLE, ADDR_W'($urandom), TEXEL_W'($urandom), u, v);
    endtask

    task automatic wait_idle();
        valid <= 1'b0;
        burst_left = 0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_TEX_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_TEX_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        tex_w = w;
        tex_h = h;
        @(posedge clk);
    endtask

    task automatic test_empty_texture();
        set_size(0, 0);
        sample_at(0, 0);
        sample_at(17'h10000, 17'h1FFFF);
        set_size(9'h1FF, 0);
        sample_at(17'h08000, 17'h08000);
        set_size(0, 5);
        sample_at(17'h1FFFF, 0);
    endtask

    task automatic test_corners();
        logic [TEXEL_W-1:0] pat [4] = '{24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h00FF00};
        set_size(4, 3);
        for (int i = 0; i < 12; i++)
            write_texel(ADDR_W'(i), pat[i % 4] ^ TEXEL_W'(i * 24'h010203));
        write_texel(16'hFFFF, 24'hA5A5A5);
        sample_at(0, 0);
        sample_at(17'h10000, 17'h10000);
        sample_at(17'h0FFFF, 17'h0FFFF);
        sample_at(17'h1FFFF, 17'h1FFFF);
        sample_at(17'h08000, 17'h05555);
        sample_at(17'h10000, 0);
        sample_at(0, 17'h10000);
        sample_at(1, 1);
    endtask

    task automatic test_oversized();
        set_size(9'h1FF, 9'h12C);
        sample_at(17'h10000, 17'h10000);
        sample_at(17'h0FFFF, 17'h00001);
        sample_at(0, 17'h1FFFF);
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        logic [COORD_W-1:0] u, v;
        set_size(w, h);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == PHASE_ITEMS / 2)
                wait_idle();
            if ($urandom_range(0, 99) < 15)
                write_texel(ADDR_W'($urandom), TEXEL_W'($urandom));
            else
            begin
                for (int c = 0; c < 2; c++)
                begin
                    case ($urandom_range(0, 9))
                        0: v = COORD_W'($urandom);
                        1: v = ($urandom_range(0, 1)) ? 17'h10000 : 17'h0FFFF;
                        2: v = COORD_W'($urandom_range(0, 1));
                        default: v = COORD_W'($urandom_range(0, 65536));
                    endcase
                    if (c == 0)
                        u = v;
                end
                sample_at(u, v);
            end
        end
    endtask

    task automatic test_random_sizes();
        run_phase(1, 1);
        run_phase(2, 2);
        run_phase(256, 256);
        run_phase(9'h1FF, 9'h1FF);
        run_phase(3, 200);
        run_phase(256, 1);
        run_phase(100, 37);
        run_phase(SIZE_W'($urandom_range(1, 300)), SIZE_W'($urandom_range(1, 300)));
    endtask

    // receiver stall pattern: none, light, heavy
    int stall_mode = 0;
    int stall_age = 0;
    always @(posedge clk)
    begin
        if (stall_age == 63)
            stall_mode <= $urandom_range(0, 2);
        stall_age <= (stall_age + 1) % 64;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("ERROR t=%0t sample word with none expected", $realtime);
                errors++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample_red !== want.red)
                    report("sample_red", sample_red, want.red);
                if (sample_green !== want.green)
                    report("sample_green", sample_green, want.green);
                if (sample_blue !== want.blue)
                    report("sample_blue", sample_blue, want.blue);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((valid && !stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_texture();
        test_corners();
        test_oversized();
        test_random_sizes();
        wait_idle();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/bts_pkg.sv
design/bts_ram.sv
design/bts_sample.sv
design/bts_blend.sv
design/bilinear_texture_sampler.sv
dv/tb.sv
